/* rtl/dual_pattern_proximity_scan_defines.svh */
// assertion macros shared by the proximity scan modules
`ifndef DUAL_PATTERN_PROXIMITY_SCAN_DEFINES_SVH
`define DUAL_PATTERN_PROXIMITY_SCAN_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication check
`define DPPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication check
`define DPPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DPPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DPPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/dpps_pkg.sv */
// shared constants, types and the pattern compare function of the proximity scan
`timescale 1ns / 1ps
package dpps_pkg;

    // geometry of the scan
    localparam int PB       = 8;
    localparam int MAX_GAP  = 16;
    localparam int GAP_LOW  = 4;
    localparam int WIN_SPAN = GAP_LOW + MAX_GAP;

    // field and register widths
    localparam int BYTE_W     = 8;
    localparam int WIN_W      = PB * BYTE_W;
    localparam int PAT_W      = 64;
    localparam int LEN_W      = 4;
    localparam int K_W        = $clog2(PB + 1);
    localparam int REM_W      = $clog2(PB);
    localparam int POS_W      = 32;
    localparam int S_W        = POS_W + 1;
    localparam int MAP_W      = WIN_SPAN + 1;
    localparam int TAIL_W     = $clog2(WIN_SPAN);
    localparam int QDEPTH     = 4;
    localparam int QA_W       = $clog2(QDEPTH);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_PATTERN  = 2'd0,
        CFG_FIRST_LENGTH   = 2'd1,
        CFG_SECOND_PATTERN = 2'd2,
        CFG_SECOND_LENGTH  = 2'd3
    } t_cfg_index;

    // front sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_HITS = 4'b0010,
        ST_TAIL = 4'b0100,
        ST_DONE = 4'b1000
    } t_front_state;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              final_byte;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] anchor_offset;
        logic             anchor_valid;
        logic             run_last;
        logic             stream_done;
    } t_out_item;

    typedef struct packed {
        logic [PAT_W-1:0] first_pattern;
        logic [LEN_W-1:0] first_length;
        logic [PAT_W-1:0] second_pattern;
        logic [LEN_W-1:0] second_length;
    } t_cfg;

    // one map shift for the back end
    typedef struct packed {
        logic             first_hit;
        logic             second_hit;
        logic             decide;
        logic [POS_W-1:0] anchor;
        logic             step_last;
        logic             done;
    } t_tick;

    // pattern starting avail bytes before the window end, all its bytes present
    function automatic logic pattern_hit(
        input logic [WIN_W-1:0] win,
        input logic [K_W-1:0]   avail,
        input logic [PAT_W-1:0] pat,
        input logic [LEN_W-1:0] len
    );
        logic [K_W-1:0]   use_len;
        logic [K_W-1:0]   shift_bytes;
        logic [WIN_W-1:0] aligned;
        logic             ok;
        use_len     = (len > LEN_W'(PB)) ? K_W'(PB) : K_W'(len);
        shift_bytes = K_W'(PB) - avail;
        aligned     = win >> {shift_bytes, 3'b000};
        ok          = (use_len != '0) && (use_len <= avail);
        for (int j = 0; j < PB; j++) begin
            if ((K_W'(j) < use_len) &&
                (aligned[j*BYTE_W +: BYTE_W] != pat[j*BYTE_W +: BYTE_W])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

/* rtl/dual_pattern_proximity_scan.sv */
// top level of the two-pattern proximity scan: config registers, front, queue, back
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------
//   in      | in        | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//   out     | out       | o_out_valid / i_out_stall | o_out_data (t_out_item)
//   cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// the front takes a byte whenever it is idle and the queue has room; a tick that yields two
// anchors holds the back end's output register for both, the four-entry queue absorbs an
// occasional one and a steady run of them halves the byte rate.
// the final byte makes the front sequence min(count, 7) + 20 flush ticks and a done tick,
// one per cycle while the queue has room, and it takes no new byte until the done tick is
// queued, which takes longer when many flush ticks yield two anchors.
// reset is synchronous and clears the window, position, hit maps, queue and registers.
// a stall at the output backs up through the queue into o_in_stall; config is always ready.
`timescale 1ns / 1ps
module dual_pattern_proximity_scan (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  dpps_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output dpps_pkg::t_out_item                o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dpps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dpps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    dpps_pkg::t_cfg    r_cfg;
    logic              w_push;
    dpps_pkg::t_tick   w_push_data;
    logic              w_full;
    logic              w_pop;
    logic              w_empty;
    dpps_pkg::t_tick   w_head;

    assign o_cfg_ready = 1'b1;

    // configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_pattern  <= '0;
            r_cfg.first_length   <= dpps_pkg::LEN_RESET;
            r_cfg.second_pattern <= '0;
            r_cfg.second_length  <= dpps_pkg::LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dpps_pkg::CFG_FIRST_PATTERN: begin
                    r_cfg.first_pattern <= i_cfg_data[dpps_pkg::PAT_W-1:0];
                end
                dpps_pkg::CFG_FIRST_LENGTH: begin
                    r_cfg.first_length <= i_cfg_data[dpps_pkg::LEN_W-1:0];
                end
                dpps_pkg::CFG_SECOND_PATTERN: begin
                    r_cfg.second_pattern <= i_cfg_data[dpps_pkg::PAT_W-1:0];
                end
                dpps_pkg::CFG_SECOND_LENGTH: begin
                    r_cfg.second_length <= i_cfg_data[dpps_pkg::LEN_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // byte intake and classification
    dpps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg       (r_cfg),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // decoupling queue
    dpps_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_empty     (w_empty),
        .o_head      (w_head)
    );

    // anchor decision and output
    dpps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/dpps_front.sv */
// front end: byte window, position count, hit classification and end-of-image flush
`timescale 1ns / 1ps
`include "dual_pattern_proximity_scan_defines.svh"
module dpps_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dpps_pkg::t_in_item  i_in_data,
    input  dpps_pkg::t_cfg      i_cfg,
    input  logic                i_q_full,
    output logic                o_push,
    output dpps_pkg::t_tick     o_push_data
);

    dpps_pkg::t_front_state              r_state, n_state;
    logic [dpps_pkg::WIN_W-1:0]          r_window, n_window;
    logic [dpps_pkg::POS_W-1:0]          r_count, n_count;
    logic [dpps_pkg::S_W-1:0]            r_s, n_s;
    logic [dpps_pkg::REM_W-1:0]          r_rem, n_rem;
    logic [dpps_pkg::TAIL_W-1:0]         r_tail, n_tail;

    logic                                w_accept;
    logic                                w_sat;
    logic                                w_long;
    logic [dpps_pkg::WIN_W-1:0]          w_win_new;
    logic [dpps_pkg::S_W-1:0]            w_norm_diff;
    logic [dpps_pkg::S_W-1:0]            w_start;
    logic [dpps_pkg::S_W:0]              w_flush_diff;
    logic [dpps_pkg::REM_W-1:0]          w_kstart;

    // input transfer only when idle and the queue has room
    assign o_in_stall = (r_state != dpps_pkg::ST_IDLE) || i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    // position arithmetic, expressed on the count before increment
    assign w_sat       = &r_count;
    assign w_win_new   = {i_in_data.byte_value, r_window[dpps_pkg::WIN_W-1:dpps_pkg::BYTE_W]};
    assign w_norm_diff = {1'b0, r_count} - (w_sat ? dpps_pkg::S_W'(dpps_pkg::PB + dpps_pkg::WIN_SPAN)
                                                   : dpps_pkg::S_W'(dpps_pkg::PB + dpps_pkg::WIN_SPAN - 1));
    assign w_long      = w_sat || (r_count >= dpps_pkg::POS_W'(dpps_pkg::PB - 2));
    assign w_start     = {1'b0, r_count} - (w_sat ? dpps_pkg::S_W'(dpps_pkg::PB - 1)
                                                  : dpps_pkg::S_W'(dpps_pkg::PB - 2));
    assign w_kstart    = w_long ? dpps_pkg::REM_W'(dpps_pkg::PB - 1)
                                : r_count[dpps_pkg::REM_W-1:0] + dpps_pkg::REM_W'(1);
    assign w_flush_diff = {1'b0, r_s} - (dpps_pkg::S_W + 1)'(dpps_pkg::WIN_SPAN);

    // sequencer: one byte per transfer, then the flush ticks and the done mark
    always_comb begin
        n_state     = r_state;
        n_window    = r_window;
        n_count     = r_count;
        n_s         = r_s;
        n_rem       = r_rem;
        n_tail      = r_tail;
        o_push      = 1'b0;
        o_push_data = '0;
        case (r_state)
            dpps_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_window = w_win_new;
                    n_count  = w_sat ? r_count : r_count + dpps_pkg::POS_W'(1);
                    if (w_sat || (r_count >= dpps_pkg::POS_W'(dpps_pkg::PB - 1))) begin
                        o_push                 = 1'b1;
                        o_push_data.first_hit  = dpps_pkg::pattern_hit(w_win_new,
                            dpps_pkg::K_W'(dpps_pkg::PB), i_cfg.first_pattern, i_cfg.first_length);
                        o_push_data.second_hit = dpps_pkg::pattern_hit(w_win_new,
                            dpps_pkg::K_W'(dpps_pkg::PB), i_cfg.second_pattern, i_cfg.second_length);
                        o_push_data.decide     = !w_norm_diff[dpps_pkg::S_W-1];
                        o_push_data.anchor     = w_norm_diff[dpps_pkg::POS_W-1:0];
                        o_push_data.step_last  = !i_in_data.final_byte;
                    end
                    if (i_in_data.final_byte) begin
                        n_state = dpps_pkg::ST_HITS;
                        n_rem   = w_kstart;
                        n_s     = w_long ? w_start : '0;
                    end
                end
            end
            dpps_pkg::ST_HITS: begin
                if (!i_q_full) begin
                    o_push                 = 1'b1;
                    o_push_data.first_hit  = dpps_pkg::pattern_hit(r_window,
                        dpps_pkg::K_W'(r_rem), i_cfg.first_pattern, i_cfg.first_length);
                    o_push_data.second_hit = dpps_pkg::pattern_hit(r_window,
                        dpps_pkg::K_W'(r_rem), i_cfg.second_pattern, i_cfg.second_length);
                    o_push_data.decide     = !w_flush_diff[dpps_pkg::S_W];
                    o_push_data.anchor     = w_flush_diff[dpps_pkg::POS_W-1:0];
                    n_s   = r_s + dpps_pkg::S_W'(1);
                    n_rem = r_rem - dpps_pkg::REM_W'(1);
                    if (r_rem == dpps_pkg::REM_W'(1)) begin
                        n_state = dpps_pkg::ST_TAIL;
                        n_tail  = dpps_pkg::TAIL_W'(dpps_pkg::WIN_SPAN - 1);
                    end
                end
            end
            dpps_pkg::ST_TAIL: begin
                if (!i_q_full) begin
                    o_push             = 1'b1;
                    o_push_data.decide = !w_flush_diff[dpps_pkg::S_W];
                    o_push_data.anchor = w_flush_diff[dpps_pkg::POS_W-1:0];
                    n_s    = r_s + dpps_pkg::S_W'(1);
                    n_tail = r_tail - dpps_pkg::TAIL_W'(1);
                    if (r_tail == '0) begin
                        n_state = dpps_pkg::ST_DONE;
                    end
                end
            end
            dpps_pkg::ST_DONE: begin
                if (!i_q_full) begin
                    o_push           = 1'b1;
                    o_push_data.done = 1'b1;
                    n_window         = '0;
                    n_count          = '0;
                    n_state          = dpps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dpps_pkg::ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dpps_pkg::ST_IDLE;
            r_window <= '0;
            r_count  <= '0;
            r_s      <= '0;
            r_rem    <= '0;
            r_tail   <= '0;
        end else begin
            r_state  <= n_state;
            r_window <= n_window;
            r_count  <= n_count;
            r_s      <= n_s;
            r_rem    <= n_rem;
            r_tail   <= n_tail;
        end
    end

    // flush hit phase always has bytes left to test
    `DPPS_ASSERT_IMP(a_hits_rem, i_clk, i_rst_n, r_state == dpps_pkg::ST_HITS, r_rem != '0, "flush hit phase with no bytes left")

endmodule

/* rtl/dpps_queue.sv */
// short show-ahead queue of map shifts between front and back end
`timescale 1ns / 1ps
`include "dual_pattern_proximity_scan_defines.svh"
module dpps_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dpps_pkg::t_tick    i_push_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output dpps_pkg::t_tick    o_head
);

    dpps_pkg::t_tick                 r_mem [dpps_pkg::QDEPTH];
    logic [dpps_pkg::QA_W-1:0]       r_wr, r_rd;
    logic [dpps_pkg::QA_W:0]         r_cnt;

    assign o_full  = (r_cnt == (dpps_pkg::QA_W + 1)'(dpps_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + dpps_pkg::QA_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + dpps_pkg::QA_W'(1);
            end
            r_cnt <= r_cnt + (dpps_pkg::QA_W + 1)'(i_push) - (dpps_pkg::QA_W + 1)'(i_pop);
        end
    end

    `DPPS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `DPPS_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")

endmodule

/* rtl/dpps_back.sv */
// back end: hit maps, anchor decision and result output register
`timescale 1ns / 1ps
`include "dual_pattern_proximity_scan_defines.svh"
module dpps_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  dpps_pkg::t_tick      i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dpps_pkg::t_out_item  o_out_data
);

    logic [dpps_pkg::MAP_W-1:0]  r_fm, n_fm;
    logic [dpps_pkg::MAP_W-1:0]  r_sm, n_sm;
    logic                        r_p1, n_p1;
    logic                        r_p2, n_p2;
    logic                        r_pd, n_pd;
    logic [dpps_pkg::POS_W-1:0]  r_off, n_off;
    logic                        r_last, n_last;
    logic                        r_out_valid, n_out_valid;
    dpps_pkg::t_out_item         r_out, n_out;

    logic                        w_out_free;
    logic                        w_any;
    logic                        w_one;
    logic [dpps_pkg::MAP_W-1:0]  w_fm_sh;
    logic [dpps_pkg::MAP_W-1:0]  w_sm_sh;
    logic                        w_hit1;
    logic                        w_hit2;

    // output slot and pending results
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_any      = r_p1 || r_p2 || r_pd;
    assign w_one      = r_pd || (r_p1 ^ r_p2);
    assign o_pop      = !i_empty && (!w_any || (w_out_free && w_one));

    // shifted maps and the two anchor tests
    assign w_fm_sh = {r_fm[dpps_pkg::MAP_W-2:0], i_head.first_hit};
    assign w_sm_sh = {r_sm[dpps_pkg::MAP_W-2:0], i_head.second_hit};
    assign w_hit1  = i_head.decide && w_fm_sh[dpps_pkg::WIN_SPAN]
                     && (|w_sm_sh[dpps_pkg::WIN_SPAN-dpps_pkg::GAP_LOW:0]);
    assign w_hit2  = i_head.decide && w_sm_sh[dpps_pkg::WIN_SPAN]
                     && (|w_fm_sh[dpps_pkg::WIN_SPAN-dpps_pkg::GAP_LOW:0]);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // emit one pending result per transfer slot, then take the next tick
    always_comb begin
        n_fm        = r_fm;
        n_sm        = r_sm;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_pd        = r_pd;
        n_off       = r_off;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_out_free) begin
            n_out_valid = w_any;
            if (r_p1) begin
                n_out.anchor_offset = r_off;
                n_out.anchor_valid  = 1'b1;
                n_out.run_last      = r_last && !r_p2;
                n_out.stream_done   = 1'b0;
                n_p1                = 1'b0;
            end else if (r_p2) begin
                n_out.anchor_offset = r_off;
                n_out.anchor_valid  = 1'b1;
                n_out.run_last      = r_last;
                n_out.stream_done   = 1'b0;
                n_p2                = 1'b0;
            end else if (r_pd) begin
                n_out.anchor_offset = '0;
                n_out.anchor_valid  = 1'b0;
                n_out.run_last      = 1'b1;
                n_out.stream_done   = 1'b1;
                n_pd                = 1'b0;
            end
        end
        if (o_pop) begin
            if (i_head.done) begin
                n_fm = '0;
                n_sm = '0;
                n_pd = 1'b1;
            end else begin
                n_fm   = w_fm_sh;
                n_sm   = w_sm_sh;
                n_p1   = w_hit1;
                n_p2   = w_hit2;
                n_off  = i_head.anchor;
                n_last = i_head.step_last;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fm        <= '0;
            r_sm        <= '0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_pd        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fm        <= n_fm;
            r_sm        <= n_sm;
            r_p1        <= n_p1;
            r_p2        <= n_p2;
            r_pd        <= n_pd;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_off  <= n_off;
        r_last <= n_last;
        r_out  <= n_out;
    end

    `DPPS_ASSERT_IMP(a_done_alone, i_clk, i_rst_n, r_pd, !r_p1 && !r_p2, "done pending beside an anchor")
    `DPPS_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n, o_pop && i_head.done, r_pd && (r_fm == '0) && (r_sm == '0), "done tick left hit maps set")

endmodule
